// ----- hw/rtl/audio_echo_mixer_defines.svh -----
// Assertion macros shared by the echo mixer RTL.
// Each use expects clk and rst in scope; no other dependencies.
`ifndef AUDIO_ECHO_MIXER_DEFINES_SVH
`define AUDIO_ECHO_MIXER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AEM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/aem_pkg.sv -----
// Shared constants, types and helpers for the echo mixer.
// No dependencies; used by aem_if, aem_apb_regs, aem_serial_div and the top level.
package aem_pkg;

  // Ring depth; must be a power of two (pointer math wraps by truncation).
  localparam int MAX_DELAY = 8192;
  localparam int PTR_W     = $clog2(MAX_DELAY);
  localparam int CNT_W     = $clog2(MAX_DELAY + 1);

  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 14;
  localparam int DIV_W     = 15;
  localparam int STEP_W    = $clog2(SAMPLE_W);

  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [DELAY_W-1:0] DELAY_RESET   = DELAY_W'(8000);
  localparam logic [DIV_W-1:0]   DIVISOR_RESET = DIV_W'(4);

  // Register indexes
  localparam logic REG_DELAY   = 1'b0;
  localparam logic REG_DIVISOR = 1'b1;

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_samples;
    logic [DIV_W-1:0]   volume_divisor;
  } aem_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aem_div_stat_t;

  // Delay clamped to 1..MAX_DELAY.
  function automatic logic [CNT_W-1:0] eff_delay(input logic [DELAY_W-1:0] d);
    logic [31:0] dw;
    dw = 32'(d);
    if (dw == 32'd0) dw = 32'd1;
    if (dw > 32'(MAX_DELAY)) dw = 32'(MAX_DELAY);
    return CNT_W'(dw);
  endfunction

  // Zero divisor behaves as one.
  function automatic logic [DIV_W-1:0] eff_divisor(input logic [DIV_W-1:0] v);
    return (v == '0) ? DIV_W'(1) : v;
  endfunction

endpackage

// ----- hw/rtl/aem_if.sv -----
// Valid/ready stream interfaces for the echo mixer input and output channels.
// Depends on aem_pkg for field widths.
interface aem_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [aem_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output cmd, output sample_in, input ready);
  modport sink   (input valid, input cmd, input sample_in, output ready);
endinterface

interface aem_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [aem_pkg::SAMPLE_W-1:0] sample_out;
  logic                             tail_last;

  modport source (output valid, output sample_out, output tail_last, input ready);
  modport sink   (input valid, input sample_out, input tail_last, output ready);
endinterface

// ----- hw/rtl/aem_apb_regs.sv -----
// APB-style configuration registers: echo delay and volume divisor.
// Depends on aem_pkg.
module aem_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aem_pkg::APB_AW-1:0]    paddr,
  input  logic [aem_pkg::APB_DW-1:0]    pwdata,
  output logic [aem_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output aem_pkg::aem_cfg_t             cfg
);

  logic [aem_pkg::DELAY_W-1:0] delay_samples;
  logic [aem_pkg::DIV_W-1:0]   volume_divisor;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples  <= aem_pkg::DELAY_RESET;
      volume_divisor <= aem_pkg::DIVISOR_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        aem_pkg::REG_DELAY:   delay_samples  <= pwdata[aem_pkg::DELAY_W-1:0];
        aem_pkg::REG_DIVISOR: volume_divisor <= pwdata[aem_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      aem_pkg::REG_DELAY:   prdata = aem_pkg::APB_DW'(delay_samples);
      aem_pkg::REG_DIVISOR: prdata = aem_pkg::APB_DW'(volume_divisor);
      default:              prdata = '0;
    endcase
  end

  assign cfg.delay_samples  = delay_samples;
  assign cfg.volume_divisor = volume_divisor;

endmodule

// ----- hw/rtl/aem_ring_ram.sv -----
// Generic simple dual-port RAM, read-first, registered read data.
// No dependencies.
module aem_ring_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/aem_serial_div.sv -----
// Bit-serial restoring divider: signed sample / positive divisor, truncating.
// One quotient bit per cycle. Depends on aem_pkg.
module aem_serial_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [aem_pkg::SAMPLE_W-1:0]  dividend,
  input  logic [aem_pkg::DIV_W-1:0]            divisor,
  output logic signed [aem_pkg::SAMPLE_W-1:0]  quotient,
  output aem_pkg::aem_div_stat_t               stat
);

  logic                            busy;
  logic                            done;
  logic [aem_pkg::STEP_W-1:0]      step;
  logic                            neg;
  logic [aem_pkg::SAMPLE_W-1:0]    mag;    // dividend shifts out, quotient in
  logic [aem_pkg::DIV_W-1:0]       rem;
  logic [aem_pkg::DIV_W-1:0]       dvsr;

  logic [aem_pkg::DIV_W:0]         trial;
  logic                            ge;
  logic [aem_pkg::DIV_W:0]         diff;

  assign trial = {rem, mag[aem_pkg::SAMPLE_W-1]};
  assign ge    = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == aem_pkg::STEP_W'(aem_pkg::SAMPLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[aem_pkg::SAMPLE_W-1];
      mag  <= dividend[aem_pkg::SAMPLE_W-1] ? (-dividend) : dividend;
      rem  <= '0;
      dvsr <= aem_pkg::eff_divisor(divisor);
    end else if (busy) begin
      mag <= {mag[aem_pkg::SAMPLE_W-2:0], ge};
      rem <= ge ? diff[aem_pkg::DIV_W-1:0] : trial[aem_pkg::DIV_W-1:0];
    end
  end

  assign quotient  = neg ? (-mag) : mag;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- hw/rtl/audio_echo_mixer.sv -----
// Top level of the echo mixer: sequencer, ring pointers and output register.
// Depends on aem_pkg, aem_if, aem_apb_regs, aem_ring_ram, aem_serial_div.

// Feedforward comb echo on signed 16-bit mono audio: each sample transfer
// (cmd = 0) returns x[n] + trunc(x[n-D] / V), wrapped to 16 bits, where D is
// delay_samples (register 0, byte address 0, clamped to 1..8192) and V is
// volume_divisor (register 1, byte address 4, zero acts as one). The echo
// term is zero until D samples of the current stream have arrived. After the
// stream, send flush transfers (cmd = 1, sample_in ignored): each returns one
// echo tail sample, and the D-th is flagged tail_last, after which a new
// stream starts. A sample arriving mid-flush abandons the flush and continues
// the stream. Every input transfer yields exactly one output transfer.
// Sequence: one item at a time. An item needing an echo term passes the accept
// step (ring read issued), the registered ring data (divider start), the
// bit-serial divider (one quotient bit per cycle), the quotient capture, then
// the mix into the output register. The divider sets the rate; items needing
// no echo term skip it. The output register decouples the sides, so a new
// item is accepted while the previous result waits; a second result holds in
// the mix step until the first one is taken. The ring is an 8192 x 16
// single-write, single-read RAM with no clearing pass; entries are only read
// once written in the current stream.
`include "audio_echo_mixer_defines.svh"

module audio_echo_mixer (
  input  logic                       clk,
  input  logic                       rst,
  aem_in_if.sink                     in_ch,
  aem_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aem_pkg::APB_AW-1:0] paddr,
  input  logic [aem_pkg::APB_DW-1:0] pwdata,
  output logic [aem_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for a transfer
  localparam logic [1:0] ST_READ = 2'd1;  // ring data arriving
  localparam logic [1:0] ST_DIV  = 2'd2;  // divider running
  localparam logic [1:0] ST_DONE = 2'd3;  // mix and hand to output register

  aem_pkg::aem_cfg_t      cfg;
  aem_pkg::aem_div_stat_t div_stat;

  logic [1:0]                             state;
  logic [aem_pkg::PTR_W-1:0]              write_pointer;
  logic [aem_pkg::CNT_W-1:0]              samples_seen;
  logic [aem_pkg::CNT_W-1:0]              tail_index;

  // Per-item context captured at accept; echo holds the divider quotient or zero
  logic signed [aem_pkg::SAMPLE_W-1:0]    dry;
  logic                                   need_echo;
  logic                                   item_last;
  logic signed [aem_pkg::SAMPLE_W-1:0]    echo;

  // Output register
  logic                                   out_valid;
  logic signed [aem_pkg::SAMPLE_W-1:0]    out_sample;
  logic                                   out_last;

  logic                                   in_fire;
  logic                                   is_flush;
  logic [aem_pkg::CNT_W-1:0]              d_eff;
  logic [aem_pkg::CNT_W:0]                seen_plus_k;
  logic [aem_pkg::CNT_W:0]                k_plus_1;
  logic                                   flush_last;
  logic                                   flush_echo;
  logic                                   sample_echo;
  logic [aem_pkg::PTR_W-1:0]              rd_addr;
  logic [aem_pkg::SAMPLE_W-1:0]           rd_data;
  logic signed [aem_pkg::SAMPLE_W-1:0]    quotient;
  logic                                   div_start;
  logic                                   out_load;

  aem_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_flush    = (in_ch.cmd == aem_pkg::CMD_FLUSH);

  assign d_eff       = aem_pkg::eff_delay(cfg.delay_samples);
  assign seen_plus_k = {1'b0, samples_seen} + {1'b0, tail_index};
  assign k_plus_1    = {1'b0, tail_index} + 1'b1;
  assign flush_last  = k_plus_1 >= {1'b0, d_eff};
  assign flush_echo  = (tail_index < d_eff) && (seen_plus_k >= {1'b0, d_eff});
  assign sample_echo = samples_seen >= d_eff;

  // Delayed sample sits at write_pointer - D (+ tail offset); wraps mod depth.
  assign rd_addr = write_pointer - d_eff[aem_pkg::PTR_W-1:0]
                 + (is_flush ? tail_index[aem_pkg::PTR_W-1:0] : '0);

  aem_ring_ram #(
    .DEPTH (aem_pkg::MAX_DELAY),
    .WIDTH (aem_pkg::SAMPLE_W)
  ) u_ring (
    .clk   (clk),
    .we    (in_fire && !is_flush),
    .waddr (write_pointer),
    .wdata (in_ch.sample_in),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign div_start = (state == ST_READ) && need_echo;

  aem_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (cfg.volume_divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign out_load = (state == ST_DONE) && (!out_valid || out_ch.ready);

  // Sequencer and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_pointer <= '0;
      samples_seen  <= '0;
      tail_index    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_READ;
            if (!is_flush) begin
              write_pointer <= write_pointer + 1'b1;
              if (samples_seen < aem_pkg::CNT_W'(aem_pkg::MAX_DELAY)) begin
                samples_seen <= samples_seen + 1'b1;
              end
              tail_index <= '0;
            end else if (flush_last) begin
              write_pointer <= '0;
              samples_seen  <= '0;
              tail_index    <= '0;
            end else begin
              tail_index <= k_plus_1[aem_pkg::CNT_W-1:0];
            end
          end
        end
        ST_READ: begin
          state <= need_echo ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item context
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dry       <= is_flush ? '0 : in_ch.sample_in;
      need_echo <= is_flush ? flush_echo : sample_echo;
      item_last <= is_flush && flush_last;
    end
    if (state == ST_READ) begin
      echo <= '0;
    end else if (div_stat.done) begin
      echo <= quotient;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= dry + echo;   // wraps to 16 bits
      out_last   <= item_last;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.tail_last  = out_last;

  `AEM_ASSERT_IMPLY(a_idle_div_quiet, state == ST_IDLE, !div_stat.busy, "divider busy while idle")
  `AEM_ASSERT_IMPLY(a_done_in_div, div_stat.done, state == ST_DIV, "divider done outside DIV")
  `AEM_ASSERT_NEXT(a_last_restarts, in_fire && is_flush && flush_last, (write_pointer == '0) && (samples_seen == '0) && (tail_index == '0), "stream not restarted after last tail")
  `AEM_ASSERT_IMPLY(a_seen_bound, 1'b1, samples_seen <= aem_pkg::CNT_W'(aem_pkg::MAX_DELAY), "sample count above ring depth")
  `AEM_ASSERT_NEXT(a_load_keeps_valid, out_load, out_valid, "output register lost loaded result")

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for audio_echo_mixer: echo mix, flush tails, register setup.
// Uses aem_pkg and the aem_in_if / aem_out_if stream interfaces from the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Values the registers hold out of reset
  localparam logic [aem_pkg::DELAY_W-1:0] DELAY_AT_RESET   = 14'd8000;
  localparam logic [aem_pkg::DIV_W-1:0]   DIVISOR_AT_RESET = 15'd4;

  // Random part runs until this many transfers have gone in
  localparam int RANDOM_ITEMS = 1680;

  typedef struct {
    logic signed [aem_pkg::SAMPLE_W-1:0] sample_out;
    logic                                tail_last;
  } echo_result_t;

  // Tracks the block's stream state, predicts every output and checks it.
  class echo_scoreboard;
    logic signed [aem_pkg::SAMPLE_W-1:0] history [aem_pkg::MAX_DELAY];
    bit [aem_pkg::PTR_W-1:0]             wr_slot;
    int unsigned                         stream_len;   // saturates at MAX_DELAY
    int unsigned                         tail_pos;     // flush transfers already returned
    bit [aem_pkg::DELAY_W-1:0]           delay_reg;
    bit [aem_pkg::DIV_W-1:0]             divisor_reg;
    echo_result_t                        expected_mix[$];
    int unsigned                         mismatches;
    int unsigned                         results_seen;

    function new();
      wr_slot      = '0;
      stream_len   = 0;
      tail_pos     = 0;
      delay_reg    = DELAY_AT_RESET;
      divisor_reg  = DIVISOR_AT_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_register(input logic idx, input logic [aem_pkg::APB_DW-1:0] value);
      if (idx == aem_pkg::REG_DELAY) delay_reg = value[aem_pkg::DELAY_W-1:0];
      else                           divisor_reg = value[aem_pkg::DIV_W-1:0];
    endfunction

    // Delayed sample scaled down; integer division truncates toward zero.
    function int scaled_echo(input logic signed [aem_pkg::SAMPLE_W-1:0] v);
      int dv;
      dv = (divisor_reg == '0) ? 1 : int'(divisor_reg);
      return int'(v) / dv;
    endfunction

    // Called on every input transfer; returns the predicted tail_last.
    function bit note_item(input logic cmd, input logic signed [aem_pkg::SAMPLE_W-1:0] x);
      int unsigned  d;
      int unsigned  k;
      int           mixed;
      bit           last;
      echo_result_t r;
      d = (delay_reg == '0) ? 1 :
          ((int'(delay_reg) > aem_pkg::MAX_DELAY) ? aem_pkg::MAX_DELAY : int'(delay_reg));
      last = 1'b0;
      if (cmd == aem_pkg::CMD_SAMPLE) begin
        mixed = int'(x);
        if (stream_len >= d)
          mixed += scaled_echo(history[(int'(wr_slot) + aem_pkg::MAX_DELAY - d)
                                       % aem_pkg::MAX_DELAY]);
        history[wr_slot] = x;
        wr_slot = wr_slot + 1'b1;
        if (stream_len < aem_pkg::MAX_DELAY) stream_len++;
        tail_pos = 0;
      end else begin
        k = tail_pos;
        mixed = 0;
        if (k < d && stream_len + k >= d)
          mixed = scaled_echo(history[(int'(wr_slot) + aem_pkg::MAX_DELAY - d + k)
                                      % aem_pkg::MAX_DELAY]);
        if (k + 1 >= d) begin
          // tail done: the next sample opens a fresh stream
          last = 1'b1;
          wr_slot = '0;
          stream_len = 0;
          tail_pos = 0;
        end else begin
          tail_pos = k + 1;
        end
      end
      r.sample_out = mixed[aem_pkg::SAMPLE_W-1:0];
      r.tail_last  = last;
      expected_mix.push_back(r);
      return last;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
      mismatches++;
    endtask

    task check_result(input logic signed [aem_pkg::SAMPLE_W-1:0] y, input logic last);
      echo_result_t want;
      results_seen++;
      if (expected_mix.size() == 0) begin
        report_mismatch($sformatf("output %0d tail_last=%0b with nothing pending", y, last));
        return;
      end
      want = expected_mix.pop_front();
      if (y !== want.sample_out)
        report_mismatch($sformatf("sample_out %0d, predicted %0d", y, want.sample_out));
      if (last !== want.tail_last)
        report_mismatch($sformatf("tail_last %0b, predicted %0b", last, want.tail_last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [aem_pkg::APB_AW-1:0] paddr;
  logic [aem_pkg::APB_DW-1:0] pwdata;
  logic [aem_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  aem_in_if  in_ch ();
  aem_out_if out_ch ();

  audio_echo_mixer u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  echo_scoreboard echo_sb = new();

  // Stimulus bookkeeping for the closing summary
  int unsigned n_samples;
  int unsigned n_flushes;
  int unsigned n_streams;
  int unsigned n_writes;
  int unsigned items_sent;
  bit          rush_in;      // no sender gaps for the current run of 64 items

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly full-range noise, with the rails and small values near zero mixed in
  // so the truncation toward zero and the 16-bit wrap get hit often.
  function automatic logic signed [aem_pkg::SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return $signed(16'($urandom_range(0, 16))) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // One input transfer. Valid stays high across back-to-back items, so it is
  // only lowered when a gap is drawn.
  task automatic send_item(input logic cmd,
                           input logic signed [aem_pkg::SAMPLE_W-1:0] smp,
                           output bit last);
    int gap;
    if (items_sent % 64 == 0) rush_in = ($urandom_range(0, 3) == 0);
    items_sent++;
    gap = rush_in ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.sample_in <= smp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    last = echo_sb.note_item(cmd, smp);
    if (cmd == aem_pkg::CMD_SAMPLE) n_samples++;
    else                            n_flushes++;
    if (last) n_streams++;
  endtask

  task automatic push_sample(input logic signed [aem_pkg::SAMPLE_W-1:0] x);
    bit last;
    send_item(aem_pkg::CMD_SAMPLE, x, last);
  endtask

  // Flush payload is ignored by the block; random bits keep the field toggling.
  task automatic push_flush(output bit last);
    send_item(aem_pkg::CMD_FLUSH, 16'($urandom), last);
  endtask

  // Register write, only once the block has drained: setup cycle, then access.
  task automatic configure(input logic idx, input logic [aem_pkg::APB_DW-1:0] value);
    in_ch.valid <= 1'b0;
    while (echo_sb.expected_mix.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= aem_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    echo_sb.set_register(idx, value);
    n_writes++;
  endtask

  // Result side: ready may drop before each transfer, with runs
  // of 64 transfers where it never drops.
  initial begin : result_sink
    int          stall;
    int unsigned taken;
    bit          rush_out;
    taken = 0;
    rush_out = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) rush_out = ($urandom_range(0, 3) == 0);
      taken++;
      stall = rush_out ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      echo_sb.check_result(out_ch.sample_out, out_ch.tail_last);
    end
  end

  initial begin : stimulus
    bit          last;
    int unsigned span;
    int unsigned len;
    int unsigned random_items;
    int unsigned start_count;

    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= aem_pkg::CMD_SAMPLE;
    in_ch.sample_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    n_samples = 0;
    n_flushes = 0;
    n_streams = 0;
    n_writes = 0;
    items_sent = 0;
    rush_in = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // Reset settings (delay 8000, divisor 4): both rails, no echo yet.
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    // Shorten the delay mid-stream; divisor stays at its reset value.
    // Echo of the rails and truncation of -7/4 toward zero.
    configure(aem_pkg::REG_DELAY, 32'd2);
    push_sample(16'sd0);
    push_sample(-16'sd7);
    push_sample(16'sd3);
    push_sample(16'sh7FFF);
    do push_flush(last); while (!last);
    // Delay zero acts as one, divisor zero as no attenuation: sums wrap.
    configure(aem_pkg::REG_DELAY, 32'd0);
    configure(aem_pkg::REG_DIVISOR, 32'd0);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_flush(last);
    // Stream shorter than the delay: early tail entries are zero.
    configure(aem_pkg::REG_DELAY, 32'd3);
    configure(aem_pkg::REG_DIVISOR, 32'd32767);
    push_sample(16'sh8000);
    do push_flush(last); while (!last);
    // A sample mid-flush drops the flush and extends the same stream.
    configure(aem_pkg::REG_DIVISOR, 32'd1);
    push_sample(16'sd100);
    push_sample(-16'sd200);
    push_sample(16'sd300);
    push_sample(-16'sd400);
    push_flush(last);
    push_sample(16'sd500);
    do push_flush(last); while (!last);

    // ---- Longest delay ----
    // All-ones delay clamps to the ring depth, then the exact maximum; the
    // stream stays shorter than the delay, so tails are zero until the delay
    // shrinks under the flush position and ends the stream.
    configure(aem_pkg::REG_DELAY, 32'h3FFF);
    configure(aem_pkg::REG_DIVISOR, 32'd3);
    repeat (100) push_sample(draw_sample());
    configure(aem_pkg::REG_DELAY, 32'(aem_pkg::MAX_DELAY));
    repeat (50) push_sample(draw_sample());
    repeat (40) push_flush(last);
    configure(aem_pkg::REG_DELAY, 32'd5);
    push_flush(last);

    // ---- Random part ----
    // Mostly complete streams with small delays: random length, full flush.
    // Mixed in: abandoned flushes, delay changes mid-stream, empty streams.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      start_count = n_samples + n_flushes;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0:       configure(aem_pkg::REG_DELAY, 32'd0);
          1:       configure(aem_pkg::REG_DELAY, 32'd1);
          2:       configure(aem_pkg::REG_DELAY, 32'd2);
          default: configure(aem_pkg::REG_DELAY, 32'($urandom_range(3, 48)));
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 6))
          0:       configure(aem_pkg::REG_DIVISOR, 32'd0);
          1:       configure(aem_pkg::REG_DIVISOR, 32'd1);
          2:       configure(aem_pkg::REG_DIVISOR, 32'd32767);
          3:       configure(aem_pkg::REG_DIVISOR, 32'($urandom_range(1, 32767)));
          default: configure(aem_pkg::REG_DIVISOR, 32'($urandom_range(2, 9)));
        endcase
      end
      span = (echo_sb.delay_reg == '0) ? 1 : int'(echo_sb.delay_reg);
      len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2 * span + 8);
      repeat (len) push_sample(draw_sample());
      if ($urandom_range(0, 5) == 0) begin
        configure(aem_pkg::REG_DELAY, 32'($urandom_range(1, 48)));
        span = int'(echo_sb.delay_reg);
      end
      if ($urandom_range(0, 7) == 0) begin
        // broken flush: stop partway; the next pass carries on the stream
        len = $urandom_range(1, span);
        last = 1'b0;
        while (len > 0 && !last) begin
          push_flush(last);
          len--;
        end
      end else begin
        do push_flush(last); while (!last);
      end
      random_items += (n_samples + n_flushes) - start_count;
    end

    // ---- Wind-down ----
    // Wait for every predicted result, then linger past one item's latency so
    // a stray extra transfer would still be caught.
    in_ch.valid <= 1'b0;
    while (echo_sb.expected_mix.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d sample and %0d flush transfers, %0d streams ended by a tail, %0d writes.",
             n_samples, n_flushes, n_streams, n_writes);
    $display("Checked %0d results; delays 0..16383 incl. clamping, divisors 0..32767.",
             echo_sb.results_seen);
    if (echo_sb.mismatches == 0 && echo_sb.expected_mix.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/aem_pkg.sv
hw/rtl/aem_if.sv
hw/rtl/aem_apb_regs.sv
hw/rtl/aem_ring_ram.sv
hw/rtl/aem_serial_div.sv
hw/rtl/audio_echo_mixer.sv
tb/testbench.sv
